>>> rtl/core/tepq_pkg.sv
// shared constants, types and address helper for the timed event priority queue
package tepq_pkg;

    localparam int DEPTH       = 64;
    localparam int TIME_BITS   = 48;
    localparam int TARGET_BITS = 10;
    localparam int FILL_BITS   = 7;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int COUNT_BITS  = $clog2(DEPTH + 1);

    localparam int S_TDATA_BITS = ((TIME_BITS + TARGET_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((TIME_BITS + TARGET_BITS + FILL_BITS + 7) / 8) * 8;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // logical slot chosen for a memory read
    typedef enum logic [1:0] {
        RD_HEAD = 2'd0,
        RD_LAST = 2'd1,
        RD_PREV = 2'd2
    } rd_sel_t;

    // logical slot and data chosen for a memory write
    typedef enum logic [1:0] {
        WR_ZERO  = 2'd0,
        WR_SHIFT = 2'd1,
        WR_NEXT  = 2'd2
    } wr_sel_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   time_val;
        logic [TARGET_BITS-1:0] target;
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    idx_load;
        logic    idx_dec;
        logic    cnt_inc;
        logic    pop_advance;
        logic    set_result;
        status_t result;
        logic    out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic rd_ge;
        logic idx_zero;
        logic out_free;
    } dp_stat_t;

    // logical position behind the head to physical slot of the ring
    function automatic logic [ADDR_BITS-1:0] phys_addr(
        input logic [ADDR_BITS-1:0] head,
        input logic [ADDR_BITS-1:0] lidx
    );
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= (ADDR_BITS + 1)'(DEPTH)) begin
            sum = sum - (ADDR_BITS + 1)'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/tepq_ctrl.sv
// sequencing state machine for insert, pop and result hand-off
module tepq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tepq_pkg::dp_stat_t stat,
    output tepq_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DECIDE,
        POP_DATA,
        INS_CMP,
        INS_LAST,
        RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == IDLE);

    // next state and datapath commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = DECIDE;
                end
            end
            DECIDE: begin
                priority if (stat.is_pop && stat.empty) begin
                    cmd.set_result = 1'b1;
                    cmd.result     = tepq_pkg::ST_EMPTY;
                    state_next     = RESULT;
                end else if (stat.is_pop) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = tepq_pkg::RD_HEAD;
                    state_next = POP_DATA;
                end else if (stat.full) begin
                    cmd.set_result = 1'b1;
                    cmd.result     = tepq_pkg::ST_FULL;
                    state_next     = RESULT;
                end else if (stat.empty) begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = tepq_pkg::WR_ZERO;
                    cmd.cnt_inc    = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.result     = tepq_pkg::ST_INSERTED;
                    state_next     = RESULT;
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = tepq_pkg::RD_LAST;
                    cmd.idx_load = 1'b1;
                    state_next   = INS_CMP;
                end
            end
            POP_DATA: begin
                cmd.pop_advance = 1'b1;
                cmd.set_result  = 1'b1;
                cmd.result      = tepq_pkg::ST_POPPED;
                state_next      = RESULT;
            end
            INS_CMP: begin
                // stored event not earlier: move it up one slot and keep scanning down
                if (stat.rd_ge) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = tepq_pkg::WR_SHIFT;
                    if (stat.idx_zero) begin
                        state_next = INS_LAST;
                    end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = tepq_pkg::RD_PREV;
                        cmd.idx_dec = 1'b1;
                    end
                end else begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = tepq_pkg::WR_NEXT;
                    cmd.cnt_inc    = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.result     = tepq_pkg::ST_INSERTED;
                    state_next     = RESULT;
                end
            end
            INS_LAST: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = tepq_pkg::WR_ZERO;
                cmd.cnt_inc    = 1'b1;
                cmd.set_result = 1'b1;
                cmd.result     = tepq_pkg::ST_INSERTED;
                state_next     = RESULT;
            end
            RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/tepq_dp.sv
// event ring memory, head and fill count, item and result registers
module tepq_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tepq_pkg::dp_cmd_t                   cmd,
    output tepq_pkg::dp_stat_t                  stat,
    input  logic [tepq_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tepq_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic [1:0]                          m_tuser
);

    localparam int AB = tepq_pkg::ADDR_BITS;
    localparam int CB = tepq_pkg::COUNT_BITS;
    localparam int TB = tepq_pkg::TIME_BITS;
    localparam int GB = tepq_pkg::TARGET_BITS;
    localparam int FB = tepq_pkg::FILL_BITS;
    localparam int PAD_BITS = tepq_pkg::M_TDATA_BITS - TB - GB - FB;

    // slot memory
    tepq_pkg::slot_t mem [tepq_pkg::DEPTH];

    logic              item_pop_reg;
    tepq_pkg::slot_t   item_reg;
    tepq_pkg::slot_t   rd_slot_reg;
    logic [AB-1:0]     head_reg;
    logic [CB-1:0]     count_reg;
    logic [AB-1:0]     idx_reg;
    tepq_pkg::status_t pend_status_reg;
    tepq_pkg::slot_t   pend_slot_reg;
    logic              m_valid_reg;
    tepq_pkg::status_t m_status_reg;
    tepq_pkg::slot_t   m_slot_reg;
    logic [FB-1:0]     m_fill_reg;

    logic [AB-1:0]     last_lidx;
    logic [AB-1:0]     rd_lidx;
    logic [AB-1:0]     wr_lidx;
    logic [AB-1:0]     rd_addr;
    logic [AB-1:0]     wr_addr;
    tepq_pkg::slot_t   wr_data;
    logic [CB-1:0]     count_minus;

    assign count_minus = count_reg - CB'(1);
    assign last_lidx   = count_minus[AB-1:0];

    // logical read and write positions
    always_comb begin
        unique case (cmd.rd_sel)
            tepq_pkg::RD_HEAD: rd_lidx = '0;
            tepq_pkg::RD_LAST: rd_lidx = last_lidx;
            tepq_pkg::RD_PREV: rd_lidx = idx_reg - AB'(1);
            default:           rd_lidx = '0;
        endcase
        unique case (cmd.wr_sel)
            tepq_pkg::WR_ZERO: begin
                wr_lidx = '0;
                wr_data = item_reg;
            end
            tepq_pkg::WR_SHIFT: begin
                wr_lidx = idx_reg + AB'(1);
                wr_data = rd_slot_reg;
            end
            tepq_pkg::WR_NEXT: begin
                wr_lidx = idx_reg + AB'(1);
                wr_data = item_reg;
            end
            default: begin
                wr_lidx = '0;
                wr_data = item_reg;
            end
        endcase
    end

    assign rd_addr = tepq_pkg::phys_addr(head_reg, rd_lidx);
    assign wr_addr = tepq_pkg::phys_addr(head_reg, wr_lidx);

    // memory write port and registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_slot_reg <= mem[rd_addr];
        end
    end

    // ring head and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + CB'(1);
            end else if (cmd.pop_advance) begin
                count_reg <= count_minus;
                head_reg  <= tepq_pkg::phys_addr(head_reg, AB'(1));
            end
        end
    end

    // accepted item and scan index
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_pop_reg    <= s_tuser[0];
            item_reg.time_val <= s_tdata[TB-1:0];
            item_reg.target <= s_tdata[TB+GB-1:TB];
        end
        if (cmd.idx_load) begin
            idx_reg <= last_lidx;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - AB'(1);
        end
    end

    // pending result
    always_ff @(posedge aclk) begin
        if (cmd.set_result) begin
            pend_status_reg <= cmd.result;
            if (cmd.result == tepq_pkg::ST_POPPED) begin
                pend_slot_reg <= rd_slot_reg;
            end else begin
                pend_slot_reg <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_status_reg <= pend_status_reg;
            m_slot_reg   <= pend_slot_reg;
            m_fill_reg   <= FB'(count_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, m_fill_reg, m_slot_reg.target, m_slot_reg.time_val};

    // status to the controller
    assign stat.is_pop   = item_pop_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CB'(tepq_pkg::DEPTH));
    assign stat.rd_ge    = (rd_slot_reg.time_val >= item_reg.time_val);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_free = !m_valid_reg || m_tready;

endmodule

>>> rtl/core/timed_event_priority_queue.sv
// top level of the timed event priority queue
//
//  channel  dir  tdata                                   tuser
//  s_       in   event_time, event_target                command (0 insert, 1 pop)
//  m_       out  popped_time, popped_target, fill_count  status
//
// a pop reads the head slot in DECIDE and sets its result in POP_DATA; a pop on
// empty, an insert when full and an insert into an empty queue set their result
// in DECIDE; an insert behind events not earlier shifts them in INS_CMP: the single
// write port of the slot memory moves one event up per cycle.
// reset clears count, head, output valid and state only; slots need no clearing.
// a result waiting on m_ does not block acceptance; the next result waits for it.
module timed_event_priority_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // event_time, event_target
    input  logic [tepq_pkg::S_TDATA_BITS-1:0] s_tdata,
    // command
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // popped_time, popped_target, fill_count
    output logic [tepq_pkg::M_TDATA_BITS-1:0] m_tdata,
    // status
    output logic [1:0]                        m_tuser
);

    tepq_pkg::dp_cmd_t  cmd;
    tepq_pkg::dp_stat_t stat;

    // sequencer
    tepq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and result path
    tepq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/tepq_checker.sv
// order checker for the timed event priority queue: predicts every result and compares it
`timescale 1ns / 1ps

module tepq_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // event_time, event_target
    input  logic [tepq_pkg::S_TDATA_BITS-1:0] s_tdata,
    // command
    input  logic [0:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // popped_time, popped_target, fill_count
    input  logic [tepq_pkg::M_TDATA_BITS-1:0] m_tdata,
    // status
    input  logic [1:0]                        m_tuser,
    output int                                errors,
    output int                                pending,
    output int                                n_inserted,
    output int                                n_popped,
    output int                                n_empty,
    output int                                n_full
);
    import tepq_pkg::*;

    // one predicted result item
    typedef struct {
        status_t                status;
        logic [TIME_BITS-1:0]   popped_time;
        logic [TARGET_BITS-1:0] popped_target;
        logic [FILL_BITS-1:0]   fill;
    } queue_answer_t;

    // mirror of the stored events, earliest first
    slot_t         held_events[$];
    queue_answer_t answers_due[$];

    // apply one command to the mirror and return the result it should give
    function automatic queue_answer_t apply_command(
        input logic                   is_pop,
        input logic [TIME_BITS-1:0]   ev_time,
        input logic [TARGET_BITS-1:0] ev_target
    );
        queue_answer_t ans;
        slot_t         ev;
        int            pos;
        ans.popped_time   = '0;
        ans.popped_target = '0;
        if (!is_pop) begin
            if (held_events.size() >= DEPTH) begin
                ans.status = ST_FULL;
            end else begin
                // lands after the last event that is strictly earlier
                pos = 0;
                for (int i = 0; i < held_events.size(); i++) begin
                    if (held_events[i].time_val < ev_time) begin
                        pos = i + 1;
                    end
                end
                ev.time_val = ev_time;
                ev.target   = ev_target;
                held_events.insert(pos, ev);
                ans.status = ST_INSERTED;
            end
        end else begin
            if (held_events.size() == 0) begin
                ans.status = ST_EMPTY;
            end else begin
                ev = held_events.pop_front();
                ans.popped_time   = ev.time_val;
                ans.popped_target = ev.target;
                ans.status        = ST_POPPED;
            end
        end
        ans.fill = FILL_BITS'(held_events.size());
        return ans;
    endfunction

    // count and report a mismatch
    task automatic flag_field(input string field, input logic [63:0] want_v,
                              input logic [63:0] got_v);
        errors++;
        $error("%s: expected 0x%0h, actual 0x%0h", field, want_v, got_v);
    endtask

    // compare results first, then predict the item taken at the same edge
    always @(posedge aclk) begin
        queue_answer_t want;
        if (!aresetn) begin
            held_events.delete();
            answers_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    errors++;
                    $error("result item with nothing expected, status %0d", m_tuser);
                end else begin
                    want = answers_due.pop_front();
                    if (m_tuser != want.status) begin
                        flag_field("status", 64'(want.status), 64'(m_tuser));
                    end
                    if (m_tdata[TIME_BITS-1:0] != want.popped_time) begin
                        flag_field("popped_time", 64'(want.popped_time),
                                   64'(m_tdata[TIME_BITS-1:0]));
                    end
                    if (m_tdata[TIME_BITS +: TARGET_BITS] != want.popped_target) begin
                        flag_field("popped_target", 64'(want.popped_target),
                                   64'(m_tdata[TIME_BITS +: TARGET_BITS]));
                    end
                    if (m_tdata[TIME_BITS+TARGET_BITS +: FILL_BITS] != want.fill) begin
                        flag_field("fill_count", 64'(want.fill),
                                   64'(m_tdata[TIME_BITS+TARGET_BITS +: FILL_BITS]));
                    end
                    case (want.status)
                        ST_INSERTED: n_inserted++;
                        ST_POPPED:   n_popped++;
                        ST_EMPTY:    n_empty++;
                        default:     n_full++;
                    endcase
                end
            end
            if (s_tvalid && s_tready) begin
                answers_due.push_back(apply_command(s_tuser[0], s_tdata[TIME_BITS-1:0],
                                                    s_tdata[TIME_BITS +: TARGET_BITS]));
            end
        end
        pending = answers_due.size();
    end

endmodule

>>> tb/tb.sv
// testbench top for the timed event priority queue: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import tepq_pkg::*;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // pop odds in percent for each kind of random run, from fill-only to drain-only
    localparam int POP_ODDS [5] = '{0, 20, 50, 80, 100};
    localparam int PHASE_ITEMS  = 330;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [0:0]              s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [1:0]              m_tuser;

    int errors;
    int pending;
    int n_inserted;
    int n_popped;
    int n_empty;
    int n_full;
    int sent;
    int tx_idle_pct;
    int rx_idle_pct;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    timed_event_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tepq_checker order_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .errors     (errors),
        .pending    (pending),
        .n_inserted (n_inserted),
        .n_popped   (n_popped),
        .n_empty    (n_empty),
        .n_full     (n_full)
    );

    // receiver stalls at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // offer one item after a random gap and hold it until taken
    task automatic push_item(input logic cmd, input logic [TIME_BITS-1:0] ev_time,
                             input logic [TARGET_BITS-1:0] ev_target);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_BITS'({ev_target, ev_time});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    // narrow ranges half the time so equal times are common, plus near-max and full-width values
    function automatic logic [TIME_BITS-1:0] pick_time();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return TIME_BITS'($urandom_range(15));
            1:       return ~TIME_BITS'($urandom_range(3));
            2:       return TIME_BITS'($urandom_range(4095));
            default: return wide[TIME_BITS-1:0];
        endcase
    endfunction

    function automatic logic [TARGET_BITS-1:0] pick_target();
        return TARGET_BITS'($urandom);
    endfunction

    initial begin
        int pop_pct;
        int run_len;
        int issued;
        tx_idle_pct = 8;
        rx_idle_pct = 50;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty pop, field extremes, equal times newest first
        push_item(CMD_POP, '1, '1);
        push_item(CMD_INSERT, '1, '1);
        push_item(CMD_INSERT, '0, '0);
        push_item(CMD_INSERT, TIME_BITS'(5), TARGET_BITS'(1));
        push_item(CMD_INSERT, TIME_BITS'(5), TARGET_BITS'(2));
        push_item(CMD_INSERT, TIME_BITS'(5), TARGET_BITS'(3));
        push_item(CMD_INSERT, '1, TARGET_BITS'(7));
        push_item(CMD_INSERT, TIME_BITS'(4), TARGET_BITS'(9));
        repeat (8) push_item(CMD_POP, '0, '0);
        push_item(CMD_POP, '0, '0);

        // random runs over the three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 50;
                end
                1: begin
                    tx_idle_pct = 50;
                    rx_idle_pct = 8;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // a long fill run guarantees the full case in every phase
            issued = 0;
            repeat (70) begin
                push_item(CMD_INSERT, pick_time(), pick_target());
                issued++;
            end
            while (issued < PHASE_ITEMS) begin
                pop_pct = POP_ODDS[$urandom_range(4)];
                run_len = $urandom_range(20, 80);
                repeat (run_len) begin
                    push_item(($urandom_range(99) < pop_pct) ? CMD_POP : CMD_INSERT,
                              pick_time(), pick_target());
                    issued++;
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain, then give a late stray result time to show up
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("sent %0d items across three stall patterns, directed and random runs",
                 sent);
        $display("results: %0d stored, %0d popped, %0d empty pops, %0d dropped when full",
                 n_inserted, n_popped, n_empty, n_full);
        if (errors == 0) begin
            $display("** timed_event_priority_queue: PASSED **");
        end else begin
            $display("** timed_event_priority_queue: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("** timed_event_priority_queue: FAILED **");
        $finish;
    end

endmodule

>>> timed_event_priority_queue.f
rtl/core/tepq_pkg.sv
rtl/core/tepq_ctrl.sv
rtl/core/tepq_dp.sv
rtl/core/timed_event_priority_queue.sv
tb/tepq_checker.sv
tb/tb.sv
